[hdl/s256_pkg.sv]
// Package: types, constants and round functions for the SHA-256 stream hasher.
package s256_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[hdl/s256_ram.sv]
// Generic single-port RAM with registered read.
module s256_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write the addressed entry when enabled; always read it
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/sha256_stream_hash.sv]
// SHA-256 over a byte stream: block buffer in RAM, one round unit, digest out.
// Input: byte beats are taken in IDLE; the beat that fills a block then stalls input while the
//   LOAD state reads the block from the byte-wide RAM and the ROUND and ADD states compress it.
// Final beat with f bytes in the block: the PAD state writes 0x80, zeros and the length and the
//   block is compressed, plus one more block when f >= 56 or the block was full; then 8 digest
//   beats, one per cycle while i_stall is low. No byte is taken during compression; the RAM port
//   and one round unit bound the rate. Reset: synchronous active low; loads the initial hash.
module sha256_stream_hash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  s256_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output s256_pkg::t_out_beat  o_data
);
    import s256_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_final, n_final;
    logic        r_second, n_second;
    logic        r_late, n_late;
    logic        r_ovalid;
    logic [2:0]  r_oidx;

    logic        ram_we;
    logic [5:0]  ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;

    s256_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    logic acc_in, acc_out;
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = r_ovalid && !i_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = '{digest_word: r_h[r_oidx], word_index: r_oidx,
                       last_word: (r_oidx == 3'd7)};

    // length byte for pad position
    logic [7:0] len_byte;
    assign len_byte = r_bits[{~r_fill[2:0], 3'b111} -: 8];

    // next state, buffer port
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_final  = r_final;
        n_second = r_second;
        n_late   = r_late;
        ram_we   = 1'b0;
        ram_addr = r_cnt[5:0];
        ram_wdata = 8'h00;
        case (r_state)
            ST_IDLE: begin
                ram_addr = r_fill;
                ram_wdata = i_data.message_byte;
                if (acc_in && i_data.byte_present) begin
                    ram_we = 1'b1;
                    n_fill = r_fill + 6'd1;
                end
                if (acc_in) begin
                    n_final = i_data.last_byte;
                    n_second = 1'b0;
                    n_late = 1'b0;
                    if (i_data.byte_present && r_fill == 6'd63) begin
                        n_state = ST_LOAD;
                        n_cnt = '0;
                    end else if (i_data.last_byte) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // write 0x80 once, then zeros, with the length in the last block
                ram_we = 1'b1;
                ram_addr = r_fill;
                if (!r_second) begin
                    ram_wdata = PAD_BYTE;
                    n_second = 1'b1;
                    n_late = (r_fill >= LEN_POS);
                end else if (!r_late && r_fill >= LEN_POS) begin
                    ram_wdata = len_byte;
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    n_state = ST_LOAD;
                    n_cnt = '0;
                end
            end
            ST_LOAD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd64) begin
                    n_state = ST_ROUND;
                    n_cnt = '0;
                end
            end
            ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                // pad again when the pad or the length has not gone in yet
                n_fill = '0;
                n_late = 1'b0;
                if (!r_final) n_state = ST_IDLE;
                else if (!r_second || r_late) n_state = ST_PAD;
                else n_state = ST_OUT;
            end
            ST_OUT: begin
                if (acc_out && r_oidx == 3'd7) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // round datapath
    logic [31:0] wt, t1, t2;
    always_comb begin
        wt = (r_cnt < 7'd16) ? r_w[r_cnt[3:0]] :
             r_w[r_cnt[3:0]] + sig0(r_w[4'(r_cnt[3:0] + 4'd1)]) +
             r_w[4'(r_cnt[3:0] + 4'd9)] + sig1(r_w[4'(r_cnt[3:0] + 4'd14)]);
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25)) +
             ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_cnt[5:0]] + wt;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22)) +
             ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_late   <= 1'b0;
            r_bits   <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
            for (int j = 0; j < 8; j++) r_h[j] <= START_H[j];
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_final  <= n_final;
            r_second <= n_second;
            r_late   <= n_late;
            if (acc_in && i_data.byte_present) r_bits <= r_bits + 64'd8;
            if (r_state == ST_ADD) begin
                for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                if (n_state == ST_OUT) begin
                    r_ovalid <= 1'b1;
                    r_oidx <= '0;
                end
            end
            if (acc_out) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_ovalid <= 1'b0;
                    r_bits <= '0;
                    for (int j = 0; j < 8; j++) r_h[j] <= START_H[j];
                end
            end
        end
    end

    // schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && r_cnt != 7'd0) begin
            r_w[4'((r_cnt - 7'd1) >> 2)] <=
                {r_w[4'((r_cnt - 7'd1) >> 2)][23:0], ram_rdata};
        end
        if (r_state == ST_LOAD && r_cnt == 7'd64) begin
            for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
        end
        if (r_state == ST_ROUND) begin
            r_w[r_cnt[3:0]] <= wt;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // checks
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accepted while busy");
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_OUT)) else $error("output outside out state");
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_cnt < 7'd64)) else $error("round count overrun");
endmodule

[test/sha256_stream_hash_tb.sv]
// Testbench for the SHA-256 stream hasher: directed and random messages checked against a model.
`timescale 1ns / 100ps

module sha256_stream_hash_tb;
    import s256_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    sha256_stream_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Model state of the hasher
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] bit_length;

    t_out_beat   digest_queue [$];
    int          error_count;
    int          words_checked;
    int          beats_sent;
    int          messages_done;
    bit          hold_receiver;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Run the 64 rounds over the model block
    function automatic void compress_model();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + K_TABLE[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) ^ 32'h0;
            t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void start_digest();
        for (int j = 0; j < 8; j++)
            hash_state[j] = IV_TABLE[j];
        block_fill = 0;
        bit_length = '0;
    endfunction

    // Advance the model by one beat and queue any digest words
    function automatic void predict_digest(input t_in_beat beat);
        t_out_beat word;
        if (beat.byte_present) begin
            msg_block[block_fill] = beat.message_byte;
            block_fill++;
            bit_length += 64'd8;
            if (block_fill == 64) begin
                compress_model();
                block_fill = 0;
            end
        end
        if (!beat.last_byte)
            return;
        msg_block[block_fill] = PAD_BYTE;
        block_fill++;
        if (block_fill > 56) begin
            while (block_fill < 64) begin
                msg_block[block_fill] = 8'h00;
                block_fill++;
            end
            compress_model();
            block_fill = 0;
        end
        while (block_fill < 56) begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
        end
        for (int j = 0; j < 8; j++)
            msg_block[56 + j] = bit_length[63 - 8*j -: 8];
        compress_model();
        for (int j = 0; j < 8; j++) begin
            word.digest_word = hash_state[j];
            word.word_index  = 3'(j);
            word.last_word   = (j == 7);
            digest_queue.push_back(word);
        end
        start_digest();
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Send one beat after a random gap; hold it until accepted
    task automatic send_beat(input logic [7:0] data_byte, input bit present, input bit last);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge i_clk);
        i_data.message_byte = data_byte;
        i_data.byte_present = present;
        i_data.last_byte    = last;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_digest(i_data);
        beats_sent++;
        if (last)
            messages_done++;
        @(negedge i_clk);
        i_valid = 1'b0;
        i_data  = '0;
    endtask

    task automatic send_message(input int length);
        for (int j = 0; j < length; j++)
            send_beat(8'($urandom), 1'b1, j == length - 1);
        if (length == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: random stall per beat, long hold-off on request
    initial begin
        int wait_cycles;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_stall = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_receiver = 1'b0;
            end
            wait_cycles = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                wait_cycles = 0;
            if (wait_cycles != 0) begin
                i_stall = 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(negedge i_clk); while (!(o_valid && !i_stall) && !hold_receiver
                                         && $urandom_range(0, 7) != 0);
        end
    end

    // Check each accepted digest word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest word, expected none, actual %h",
                         $time, o_data);
                error_count++;
            end else begin
                want = digest_queue.pop_front();
                words_checked++;
                if (o_data.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word mismatch, expected %h, actual %h",
                             $time, want.digest_word, o_data.digest_word);
                    error_count++;
                end
                if (o_data.word_index !== want.word_index) begin
                    $display("%0t: word_index mismatch, expected %0d, actual %0d",
                             $time, want.word_index, o_data.word_index);
                    error_count++;
                end
                if (o_data.last_word !== want.last_word) begin
                    $display("%0t: last_word mismatch, expected %0d, actual %0d",
                             $time, want.last_word, o_data.last_word);
                    error_count++;
                end
            end
        end
    end

    // Empty message, lone pad beats, and idle beats with no byte
    task automatic test_empty_and_idle();
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // Byte extremes; the final byte carried with the end mark and after it
    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'haa, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // Pad past the length field, and a full block ending on the last byte
    task automatic test_pad_boundaries();
        send_message(56);
        send_message(64);
    endtask

    // Random short messages with idle beats mixed in
    task automatic test_random_messages();
        int start_beats;
        int length;
        start_beats = beats_sent;
        while (beats_sent - start_beats < 16) begin
            case ($urandom_range(0, 9))
                0: send_beat(8'($urandom), 1'b0, 1'b0);
                default: begin
                    length = $urandom_range(0, 8);
                    send_message(length);
                end
            endcase
        end
    endtask

    // Hold the receiver off while messages keep coming in
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        for (int j = 0; j < 4; j++)
            send_message($urandom_range(0, 2));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        error_count   = 0;
        words_checked = 0;
        beats_sent    = 0;
        messages_done = 0;
        hold_receiver = 1'b0;
        start_digest();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_and_idle();
        test_byte_extremes();
        test_pad_boundaries();
        test_backpressure();
        test_random_messages();

        // Drain remaining digest words, then allow the block to settle
        while (digest_queue.size() != 0)
            @(negedge i_clk);
        repeat (300) @(negedge i_clk);

        $display("Sent %0d beats forming %0d messages; checked %0d digest words.",
                 beats_sent, messages_done, words_checked);
        $display("Covered empty messages, idle beats, pad boundaries and long stalls.");
        if (error_count == 0 && digest_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run
    initial begin
        #1ms;
        $display("Timeout with %0d digest words outstanding", digest_queue.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
